>>> hdl/tpvt_pkg.sv
// Shared types and constants for the touch point velocity tracker.
package tpvt_pkg;

  localparam int unsigned PosW    = 20;
  localparam int unsigned VelW    = 32;
  localparam int unsigned TimeW   = 32;
  localparam int unsigned GainW   = 9;
  localparam int unsigned SlotW   = 4;
  localparam int unsigned DeltaW  = 21;  // position difference
  localparam int unsigned NumW    = 31;  // difference times 1000
  localparam int unsigned QuotW   = 31;  // quotient magnitude
  localparam int unsigned SumW    = 43;  // blend sum
  localparam logic [GainW-1:0] GainOne      = 9'd256;
  localparam logic [8:0]       PressureFull = 9'd256;
  localparam logic [9:0]       MsPerS       = 10'd1000;

  typedef enum logic [1:0] {
    KIND_PRESSED    = 2'd0,
    KIND_UPDATED    = 2'd1,
    KIND_STATIONARY = 2'd2,
    KIND_RELEASED   = 2'd3
  } kind_e;

  localparam logic [0:0] RegGain   = 1'b0;
  localparam logic [0:0] RegDevVel = 1'b1;

  typedef struct packed {
    logic [SlotW-1:0]        point_slot;
    logic [1:0]              event_kind;
    logic signed [PosW-1:0]  pos_x;
    logic signed [PosW-1:0]  pos_y;
    logic [8:0]              pressure_in;
    logic                    pressure_known;
    logic [TimeW-1:0]        timestamp_ms;
    logic signed [VelW-1:0]  dev_vel_x;
    logic signed [VelW-1:0]  dev_vel_y;
  } in_word_t;

  typedef struct packed {
    logic [SlotW-1:0]        out_slot;
    logic [1:0]              out_kind;
    logic signed [PosW-1:0]  prev_x;
    logic signed [PosW-1:0]  prev_y;
    logic signed [PosW-1:0]  press_x;
    logic signed [PosW-1:0]  press_y;
    logic [8:0]              pressure_out;
    logic signed [VelW-1:0]  vel_x;
    logic signed [VelW-1:0]  vel_y;
    logic [TimeW-1:0]        held_ms;
  } out_word_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_UPDATE,
    ST_DIV_START,
    ST_DIV,
    ST_MULT_NEW,
    ST_MULT_OLD,
    ST_SAT,
    ST_AXIS_NEXT,
    ST_WRITE,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic load;        // capture input word
    logic read;        // latch record
    logic update;      // positions, times, device velocity
    logic div_start;   // set up divider for current axis
    logic div_step;    // one quotient bit
    logic mult_new;    // new velocity times gain
    logic mult_old;    // old velocity times complement
    logic sat;         // floor-shift, saturate, store axis
    logic axis_next;   // move to y axis
    logic write;       // write record back
    logic out_load;    // fill output register
  } cmd_t;

  typedef struct packed {
    logic need_vel;    // computed velocity update required
    logic div_done;
    logic axis_y;
  } sts_t;

endpackage

>>> hdl/tpvt_ctrl.sv
// Sequencer for the touch point velocity tracker.
module tpvt_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic            out_slot_busy_i,
  input  tpvt_pkg::sts_t  sts_i,
  output tpvt_pkg::cmd_t  cmd_o
);
  import tpvt_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:      if (in_valid_i) state_d = ST_READ;
      ST_READ:      state_d = ST_UPDATE;
      ST_UPDATE:    state_d = sts_i.need_vel ? ST_DIV_START : ST_WRITE;
      ST_DIV_START: state_d = ST_DIV;
      ST_DIV:       if (sts_i.div_done) state_d = ST_MULT_NEW;
      ST_MULT_NEW:  state_d = ST_MULT_OLD;
      ST_MULT_OLD:  state_d = ST_SAT;
      ST_SAT:       state_d = sts_i.axis_y ? ST_WRITE : ST_AXIS_NEXT;
      ST_AXIS_NEXT: state_d = ST_DIV_START;
      ST_WRITE:     state_d = ST_OUT;
      ST_OUT:       if (!out_slot_busy_i) state_d = ST_IDLE;
      default:      state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.load = in_valid_i;
      end
      ST_READ:      cmd_o.read = 1'b1;
      ST_UPDATE:    cmd_o.update = 1'b1;
      ST_DIV_START: cmd_o.div_start = 1'b1;
      ST_DIV:       cmd_o.div_step = 1'b1;
      ST_MULT_NEW:  cmd_o.mult_new = 1'b1;
      ST_MULT_OLD:  cmd_o.mult_old = 1'b1;
      ST_SAT:       cmd_o.sat = 1'b1;
      ST_AXIS_NEXT: cmd_o.axis_next = 1'b1;
      ST_WRITE:     cmd_o.write = 1'b1;
      ST_OUT:       cmd_o.out_load = !out_slot_busy_i;
      default:      cmd_o = '0;
    endcase
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV && !sts_i.div_done) |=> state_q == ST_DIV)
    else $error("divider left early");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> state_q == ST_READ)
    else $error("accepted word not processed");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_UPDATE && !sts_i.need_vel) |=> state_q == ST_WRITE)
    else $error("skipped write-back");
endmodule

>>> hdl/tpvt_datapath.sv
// Record table, serial divider and blend arithmetic of the tracker.
module tpvt_datapath #(
  parameter int unsigned NumPoints = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  tpvt_pkg::in_word_t       in_word_i,
  input  tpvt_pkg::cmd_t           cmd_i,
  output tpvt_pkg::sts_t           sts_o,
  input  logic [tpvt_pkg::GainW-1:0] gain_i,
  input  logic                     dev_vel_i,
  output tpvt_pkg::out_word_t      out_word_o
);
  import tpvt_pkg::*;

  localparam int unsigned IdxW = (NumPoints > 1) ? $clog2(NumPoints) : 1;

  // Record table, one register row per point, cleared at reset
  logic signed [PosW-1:0]  cur_x_q [NumPoints];
  logic signed [PosW-1:0]  cur_y_q [NumPoints];
  logic signed [PosW-1:0]  last_x_q [NumPoints];
  logic signed [PosW-1:0]  last_y_q [NumPoints];
  logic signed [PosW-1:0]  prs_x_q [NumPoints];
  logic signed [PosW-1:0]  prs_y_q [NumPoints];
  logic signed [VelW-1:0]  vel_x_q [NumPoints];
  logic signed [VelW-1:0]  vel_y_q [NumPoints];
  logic [TimeW-1:0]        tnow_q [NumPoints];
  logic [TimeW-1:0]        tbef_q [NumPoints];
  logic [TimeW-1:0]        tprs_q [NumPoints];

  in_word_t               iw_q;
  logic [IdxW-1:0]        idx_q;
  logic signed [PosW-1:0] r_cx_q, r_cy_q, r_lx_q, r_ly_q, r_px_q, r_py_q;
  logic signed [VelW-1:0] r_vx_q, r_vy_q;
  logic [TimeW-1:0]       r_tn_q, r_tb_q, r_tp_q;
  logic                   axis_q;

  // divider
  logic [NumW-1:0]  num_q;
  logic [TimeW-1:0] rem_q;
  logic [TimeW-1:0] dt_q;
  logic [4:0]       cnt_q;
  logic             neg_q, done_q;
  logic [QuotW-1:0] quo_q;
  logic signed [SumW-1:0] sum_q;
  logic signed [32:0]     newv;

  // slot modulo table depth, as a constant lookup over all slot codes
  logic [IdxW-1:0] idx_d;
  always_comb begin
    idx_d = '0;
    for (int i = 0; i < (1 << SlotW); i++) begin
      if (in_word_i.point_slot == SlotW'(i)) idx_d = IdxW'(i % NumPoints);
    end
  end

  logic [GainW-1:0] g_eff;
  assign g_eff = (gain_i > GainOne) ? GainOne : gain_i;

  logic signed [DeltaW-1:0] delta;
  logic [DeltaW-1:0]        dmag;
  logic [NumW-1:0]          nmag;
  assign delta = axis_q ? (DeltaW'(r_cy_q) - DeltaW'(r_ly_q))
                        : (DeltaW'(r_cx_q) - DeltaW'(r_lx_q));
  assign dmag  = delta[DeltaW-1] ? DeltaW'(-delta) : DeltaW'(delta);
  assign nmag  = NumW'(dmag) * NumW'(MsPerS);

  logic [TimeW:0] rem_sh;
  assign rem_sh = {rem_q, num_q[NumW-1]};

  assign newv = neg_q ? -$signed({2'b00, quo_q}) : $signed({2'b00, quo_q});

  logic signed [SumW-9:0] shifted;
  assign shifted = sum_q[SumW-1:8];

  logic signed [VelW-1:0] satv;
  always_comb begin
    if (shifted > $signed((SumW-8)'(32'sh7fffffff)))
      satv = 32'sh7fffffff;
    else if (shifted < -$signed((SumW-8)'(33'sh080000000)))
      satv = 32'sh80000000;
    else
      satv = VelW'(shifted);
  end

  logic [TimeW-1:0] t_in;
  assign t_in = iw_q.timestamp_ms;

  // decided from the record before the update is applied
  logic need_vel;
  assign need_vel = (t_in > r_tn_q) && (r_tn_q != '0) && !dev_vel_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      iw_q  <= in_word_i;
      idx_q <= idx_d;
    end
    if (cmd_i.div_start) begin
      num_q <= nmag;
      neg_q <= delta[DeltaW-1];
      rem_q <= '0;
      quo_q <= '0;
      dt_q  <= t_in - r_tb_q;
    end
    if (cmd_i.div_step) begin
      num_q <= num_q << 1;
      if (rem_sh >= {1'b0, dt_q}) begin
        rem_q <= TimeW'(rem_sh - {1'b0, dt_q});
        quo_q <= {quo_q[QuotW-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh[TimeW-1:0];
        quo_q <= {quo_q[QuotW-2:0], 1'b0};
      end
    end
    if (cmd_i.mult_new) begin
      sum_q <= SumW'(newv) * SumW'($signed({1'b0, g_eff}));
    end
    if (cmd_i.mult_old) begin
      sum_q <= sum_q + SumW'(axis_q ? r_vy_q : r_vx_q)
                * SumW'($signed({1'b0, GainOne - g_eff}));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
      axis_q <= 1'b0;
    end else begin
      if (cmd_i.div_start) begin
        cnt_q  <= 5'(QuotW - 1);
        done_q <= 1'b0;
      end else if (cmd_i.div_step) begin
        cnt_q  <= cnt_q - 5'd1;
        done_q <= (cnt_q == 5'd1);
      end
      if (cmd_i.read) axis_q <= 1'b0;
      else if (cmd_i.axis_next) axis_q <= 1'b1;
    end
  end

  // Record working copy
  always_ff @(posedge clk_i) begin
    if (cmd_i.read) begin
      r_cx_q <= cur_x_q[idx_q];  r_cy_q <= cur_y_q[idx_q];
      r_lx_q <= last_x_q[idx_q]; r_ly_q <= last_y_q[idx_q];
      r_px_q <= prs_x_q[idx_q];  r_py_q <= prs_y_q[idx_q];
      r_vx_q <= vel_x_q[idx_q];  r_vy_q <= vel_y_q[idx_q];
      r_tn_q <= tnow_q[idx_q];   r_tb_q <= tbef_q[idx_q];
      r_tp_q <= tprs_q[idx_q];
    end
    if (cmd_i.update) begin
      if (iw_q.event_kind == KIND_PRESSED) begin
        r_px_q <= iw_q.pos_x; r_py_q <= iw_q.pos_y;
        r_lx_q <= iw_q.pos_x; r_ly_q <= iw_q.pos_y;
        r_tp_q <= t_in;
      end else if (r_cx_q != iw_q.pos_x || r_cy_q != iw_q.pos_y) begin
        r_lx_q <= r_cx_q; r_ly_q <= r_cy_q;
      end
      r_cx_q <= iw_q.pos_x; r_cy_q <= iw_q.pos_y;
      if (dev_vel_i) begin
        r_vx_q <= iw_q.dev_vel_x; r_vy_q <= iw_q.dev_vel_y;
      end
      if (t_in > r_tn_q) begin
        r_tb_q <= r_tn_q;
        r_tn_q <= t_in;
      end else if (t_in < r_tn_q) begin
        r_tn_q <= t_in;
      end
    end
    if (cmd_i.sat) begin
      if (axis_q) r_vy_q <= satv;
      else        r_vx_q <= satv;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumPoints; i++) begin
        cur_x_q[i] <= '0;  cur_y_q[i] <= '0;
        last_x_q[i] <= '0; last_y_q[i] <= '0;
        prs_x_q[i] <= '0;  prs_y_q[i] <= '0;
        vel_x_q[i] <= '0;  vel_y_q[i] <= '0;
        tnow_q[i] <= '0;   tbef_q[i] <= '0;
        tprs_q[i] <= '0;
      end
    end else if (cmd_i.write) begin
      cur_x_q[idx_q] <= r_cx_q;  cur_y_q[idx_q] <= r_cy_q;
      last_x_q[idx_q] <= r_lx_q; last_y_q[idx_q] <= r_ly_q;
      prs_x_q[idx_q] <= r_px_q;  prs_y_q[idx_q] <= r_py_q;
      vel_x_q[idx_q] <= r_vx_q;  vel_y_q[idx_q] <= r_vy_q;
      tnow_q[idx_q] <= r_tn_q;   tbef_q[idx_q] <= r_tb_q;
      tprs_q[idx_q] <= r_tp_q;
    end
  end

  logic [8:0] pres;
  always_comb begin
    if (iw_q.event_kind == KIND_RELEASED) pres = '0;
    else if (iw_q.pressure_known)
      pres = (iw_q.pressure_in > PressureFull) ? PressureFull : iw_q.pressure_in;
    else pres = PressureFull;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_word_o.out_slot     <= iw_q.point_slot;
      out_word_o.out_kind     <= iw_q.event_kind;
      out_word_o.prev_x       <= r_lx_q;
      out_word_o.prev_y       <= r_ly_q;
      out_word_o.press_x      <= r_px_q;
      out_word_o.press_y      <= r_py_q;
      out_word_o.pressure_out <= pres;
      out_word_o.vel_x        <= r_vx_q;
      out_word_o.vel_y        <= r_vy_q;
      out_word_o.held_ms      <= r_tn_q - r_tp_q;
    end
  end

  assign sts_o.need_vel = need_vel;
  assign sts_o.div_done = done_q;
  assign sts_o.axis_y   = axis_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_step && !done_q |=> cnt_q == $past(cnt_q) - 5'd1)
    else $error("divider count slipped");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_start |=> dt_q != '0)
    else $error("zero time delta in divider");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.axis_next |=> axis_q)
    else $error("axis did not advance");
endmodule

>>> hdl/touch_point_velocity_tracker_unit.sv
// Top level of the touch point velocity tracker.
// One event word in gives one result word out. An event is read from its record and
// updated; when velocity is recomputed, each axis then takes a setup step, a
// restoring divider for (pos - last) * 1000 / dt, the new velocity times the gain,
// the old velocity times its complement and a saturate step, with an axis switch
// between x and y, before the record is written back. One event is processed at
// a time; the result register holds a finished word while the next event is taken,
// and a result still stalled at the output holds the next event in its output state.
module touch_point_velocity_tracker_unit #(
  parameter int unsigned NumPoints = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  tpvt_pkg::in_word_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output tpvt_pkg::out_word_t  out_data_o,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);
  import tpvt_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic [GainW-1:0] gain_q;
  logic             devv_q;
  logic             ovalid_q;
  logic             wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= 9'd179;
      devv_q <= 1'b0;
    end else if (wr_en && paddr[1:0] == 2'b00) begin
      if (paddr[2] == RegGain)   gain_q <= pwdata[GainW-1:0];
      if (paddr[2] == RegDevVel) devv_q <= pwdata[0];
    end
  end

  always_comb begin
    case (paddr[2])
      RegGain:   prdata = 32'(gain_q);
      RegDevVel: prdata = 32'(devv_q);
      default:   prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else if (cmd.out_load) begin
      ovalid_q <= 1'b1;
    end else if (!out_stall_i) begin
      ovalid_q <= 1'b0;
    end
  end
  assign out_valid_o = ovalid_q;

  tpvt_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .out_slot_busy_i (ovalid_q && out_stall_i),
    .sts_i           (sts),
    .cmd_o           (cmd)
  );

  tpvt_datapath #(.NumPoints(NumPoints)) u_dp (
    .clk_i,
    .rst_ni,
    .in_word_i  (in_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .gain_i     (gain_q),
    .dev_vel_i  (devv_q),
    .out_word_o (out_data_o)
  );

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o)
    else $error("held result dropped");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> !(ovalid_q && out_stall_i))
    else $error("result overwritten");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("second word taken during processing");
endmodule

>>> tb/sv/tb_touch_point_velocity_tracker_unit.sv
// Testbench for the touch point velocity tracker: table-driven events, then random traffic.
`timescale 1ns / 1ps

module tb_touch_point_velocity_tracker_unit;
  import tpvt_pkg::*;

  localparam int unsigned NumRecs = 16;
  localparam int unsigned RandItems = 400;
  localparam logic [2:0] AddrGain = 3'd0;
  localparam logic [2:0] AddrDevVel = 3'd4;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  in_word_t in_data_i;
  logic out_valid_o;
  logic out_stall_i;
  out_word_t out_data_o;
  logic psel;
  logic penable;
  logic pwrite;
  logic [2:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  touch_point_velocity_tracker_unit dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_data_o(out_data_o),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // predictor copy of the per-point records
  logic signed [PosW-1:0] rec_cur_x [NumRecs];
  logic signed [PosW-1:0] rec_cur_y [NumRecs];
  logic signed [PosW-1:0] rec_last_x [NumRecs];
  logic signed [PosW-1:0] rec_last_y [NumRecs];
  logic signed [PosW-1:0] rec_press_x [NumRecs];
  logic signed [PosW-1:0] rec_press_y [NumRecs];
  logic signed [VelW-1:0] rec_vel_x [NumRecs];
  logic signed [VelW-1:0] rec_vel_y [NumRecs];
  logic [TimeW-1:0] rec_t_now [NumRecs];
  logic [TimeW-1:0] rec_t_before [NumRecs];
  logic [TimeW-1:0] rec_t_press [NumRecs];
  logic [8:0] gain_q;
  logic dev_vel_q;

  out_word_t pending_results[$];
  int unsigned mismatches;
  int unsigned words_checked;
  int unsigned vel_updates;

  typedef struct {
    in_word_t ev;
    logic has_exp;
    out_word_t exp_word;
  } stim_row_t;

  stim_row_t directed_rows[$];

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #50ms;
    $display("tb: failure");
    $finish;
  end

  function automatic logic signed [VelW-1:0] point_speed(logic signed [PosW-1:0] cur,
      logic signed [PosW-1:0] last, logic [TimeW-1:0] dt);
    longint d;
    longint unsigned mag;
    longint unsigned q;
    d = (longint'(cur) - longint'(last)) * 1000;
    mag = (d < 0) ? longint'(-d) : d;
    q = mag / longint'({32'd0, dt});
    return (d < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic logic signed [VelW-1:0] smooth_speed(longint nv, longint ov,
      longint g);
    longint sum;
    longint r;
    sum = nv * g + ov * (256 - g);
    r = sum >>> 8;  // floor
    if (r > 64'sd2147483647) r = 64'sd2147483647;
    if (r < -64'sd2147483648) r = -64'sd2147483648;
    return r;
  endfunction

  function automatic out_word_t track_event(in_word_t ev);
    out_word_t o;
    int unsigned s;
    longint g;
    logic [TimeW-1:0] t;
    s = ev.point_slot % NumRecs;
    g = (gain_q > 9'd256) ? 256 : gain_q;
    t = ev.timestamp_ms;
    if (ev.event_kind == KIND_RELEASED) o.pressure_out = '0;
    else if (ev.pressure_known)
      o.pressure_out = (ev.pressure_in > PressureFull) ? PressureFull : ev.pressure_in;
    else o.pressure_out = PressureFull;
    if (ev.event_kind == KIND_PRESSED) begin
      rec_press_x[s] = ev.pos_x;
      rec_press_y[s] = ev.pos_y;
      rec_last_x[s] = ev.pos_x;
      rec_last_y[s] = ev.pos_y;
    end else if (rec_cur_x[s] != ev.pos_x || rec_cur_y[s] != ev.pos_y) begin
      rec_last_x[s] = rec_cur_x[s];
      rec_last_y[s] = rec_cur_y[s];
    end
    rec_cur_x[s] = ev.pos_x;
    rec_cur_y[s] = ev.pos_y;
    if (dev_vel_q) begin
      rec_vel_x[s] = ev.dev_vel_x;
      rec_vel_y[s] = ev.dev_vel_y;
    end
    if (ev.event_kind == KIND_PRESSED) rec_t_press[s] = t;
    if (t > rec_t_now[s]) begin
      rec_t_before[s] = rec_t_now[s];
      rec_t_now[s] = t;
      if (rec_t_before[s] != 0 && !dev_vel_q) begin
        vel_updates++;
        rec_vel_x[s] = smooth_speed(
            point_speed(rec_cur_x[s], rec_last_x[s], t - rec_t_before[s]),
            rec_vel_x[s], g);
        rec_vel_y[s] = smooth_speed(
            point_speed(rec_cur_y[s], rec_last_y[s], t - rec_t_before[s]),
            rec_vel_y[s], g);
      end
    end else if (t < rec_t_now[s]) begin
      rec_t_now[s] = t;
    end
    o.out_slot = ev.point_slot;
    o.out_kind = ev.event_kind;
    o.prev_x = rec_last_x[s];
    o.prev_y = rec_last_y[s];
    o.press_x = rec_press_x[s];
    o.press_y = rec_press_y[s];
    o.vel_x = rec_vel_x[s];
    o.vel_y = rec_vel_y[s];
    o.held_ms = rec_t_now[s] - rec_t_press[s];
    return o;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    mismatches++;
    $display("mismatch %s: got %0d want %0d (word %0d)", what, got, want, words_checked);
  endtask

  // receiver: stall pattern, compare each accepted word with the oldest expectation
  initial begin
    int unsigned mode;
    out_word_t w;
    out_stall_i = 1'b0;
    mode = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected result word, slot", out_data_o.out_slot, -1);
        end else begin
          w = pending_results.pop_front();
          if (out_data_o.out_slot !== w.out_slot)
            report_mismatch("out_slot", out_data_o.out_slot, w.out_slot);
          if (out_data_o.out_kind !== w.out_kind)
            report_mismatch("out_kind", out_data_o.out_kind, w.out_kind);
          if (out_data_o.prev_x !== w.prev_x) report_mismatch("prev_x", out_data_o.prev_x, w.prev_x);
          if (out_data_o.prev_y !== w.prev_y) report_mismatch("prev_y", out_data_o.prev_y, w.prev_y);
          if (out_data_o.press_x !== w.press_x)
            report_mismatch("press_x", out_data_o.press_x, w.press_x);
          if (out_data_o.press_y !== w.press_y)
            report_mismatch("press_y", out_data_o.press_y, w.press_y);
          if (out_data_o.pressure_out !== w.pressure_out)
            report_mismatch("pressure_out", out_data_o.pressure_out, w.pressure_out);
          if (out_data_o.vel_x !== w.vel_x) report_mismatch("vel_x", out_data_o.vel_x, w.vel_x);
          if (out_data_o.vel_y !== w.vel_y) report_mismatch("vel_y", out_data_o.vel_y, w.vel_y);
          if (out_data_o.held_ms !== w.held_ms)
            report_mismatch("held_ms", out_data_o.held_ms, w.held_ms);
        end
        words_checked++;
      end
      if ($urandom_range(0, 63) == 0) mode = $urandom_range(0, 3);
      case (mode)
        0: out_stall_i <= 1'b0;
        1: out_stall_i <= ($urandom_range(0, 3) == 0);
        2: out_stall_i <= ($urandom_range(0, 1) == 0);
        default: out_stall_i <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  task automatic write_reg(logic [2:0] addr, logic [31:0] data);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == AddrGain) gain_q = data[8:0];
    else dev_vel_q = data[0];
  endtask

  int unsigned burst_left;

  // send one word; bursts of random length with random gaps between them
  task automatic send_event(in_word_t ev, logic has_exp, out_word_t exp_word);
    out_word_t p;
    if (burst_left == 0) begin
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_valid_i <= 1'b1;
    in_data_i <= ev;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    p = track_event(ev);
    if (has_exp && p !== exp_word)
      report_mismatch("predictor against table row, slot", ev.point_slot, -1);
    pending_results.push_back(has_exp ? exp_word : p);
    if (burst_left == 0) in_valid_i <= 1'b0;
  endtask

  task automatic drain;
    int unsigned guard;
    guard = 0;
    if (burst_left != 0) in_valid_i <= 1'b0;
    burst_left = 0;
    while (pending_results.size() != 0 && guard < 200000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (100) @(posedge clk_i);
  endtask

  function automatic in_word_t mk_event(logic [3:0] slot, kind_e kind, int px, int py,
      logic [8:0] pin, logic pk, logic [31:0] t, logic [31:0] dvx, logic [31:0] dvy);
    in_word_t e;
    e.point_slot = slot;
    e.event_kind = kind;
    e.pos_x = px;
    e.pos_y = py;
    e.pressure_in = pin;
    e.pressure_known = pk;
    e.timestamp_ms = t;
    e.dev_vel_x = dvx;
    e.dev_vel_y = dvy;
    return e;
  endfunction

  function automatic out_word_t mk_result(logic [3:0] slot, kind_e kind, int lx, int ly,
      int prx, int pry, logic [8:0] pr, logic [31:0] vx, logic [31:0] vy, logic [31:0] held);
    out_word_t o;
    o.out_slot = slot;
    o.out_kind = kind;
    o.prev_x = lx;
    o.prev_y = ly;
    o.press_x = prx;
    o.press_y = pry;
    o.pressure_out = pr;
    o.vel_x = vx;
    o.vel_y = vy;
    o.held_ms = held;
    return o;
  endfunction

  task automatic add_row(in_word_t ev, logic has_exp, out_word_t exp_word);
    stim_row_t r;
    r.ev = ev;
    r.has_exp = has_exp;
    r.exp_word = exp_word;
    directed_rows.push_back(r);
  endtask

  function automatic in_word_t random_event(int unsigned slot_span);
    in_word_t e;
    logic [3:0] s;
    s = $urandom_range(0, slot_span);
    e.point_slot = s;
    e.event_kind = kind_e'($urandom_range(0, 3));
    if ($urandom_range(0, 9) == 0) begin
      e.pos_x = $urandom();
      e.pos_y = $urandom();
    end else begin
      e.pos_x = rec_cur_x[s] + $signed($urandom_range(0, 400)) - 200;
      e.pos_y = rec_cur_y[s] + $signed($urandom_range(0, 400)) - 200;
    end
    e.pressure_in = $urandom();
    e.pressure_known = $urandom();
    case ($urandom_range(0, 9))
      0: e.timestamp_ms = $urandom();
      1: e.timestamp_ms = rec_t_now[s];
      2: e.timestamp_ms = rec_t_now[s] - $urandom_range(1, 50);
      default: e.timestamp_ms = rec_t_now[s] + $urandom_range(1, 40);
    endcase
    e.dev_vel_x = $urandom();
    e.dev_vel_y = $urandom();
    return e;
  endfunction

  initial begin
    int unsigned n;
    in_word_t ev;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    mismatches = 0;
    words_checked = 0;
    vel_updates = 0;
    burst_left = 0;
    gain_q = 9'd179;
    dev_vel_q = 1'b0;
    for (int i = 0; i < NumRecs; i++) begin
      rec_cur_x[i] = '0; rec_cur_y[i] = '0; rec_last_x[i] = '0; rec_last_y[i] = '0;
      rec_press_x[i] = '0; rec_press_y[i] = '0; rec_vel_x[i] = '0; rec_vel_y[i] = '0;
      rec_t_now[i] = '0; rec_t_before[i] = '0; rec_t_press[i] = '0;
    end
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed table, reset gain
    add_row(mk_event(4'd0, KIND_STATIONARY, 0, 0, 9'd0, 1'b0, 32'd0, 0, 0), 1'b1,
        mk_result(4'd0, KIND_STATIONARY, 0, 0, 0, 0, 9'd256, 0, 0, 0));
    add_row(mk_event(4'd1, KIND_PRESSED, -524288, 524287, 9'd511, 1'b1, 32'd10, 0, 0), 1'b1,
        mk_result(4'd1, KIND_PRESSED, -524288, 524287, -524288, 524287, 9'd256, 0, 0, 0));
    add_row(mk_event(4'd1, KIND_UPDATED, 524287, -524288, 9'd128, 1'b1, 32'd11, 0, 0),
        1'b0, '0);
    add_row(mk_event(4'd1, KIND_UPDATED, -524288, 524287, 9'd0, 1'b1, 32'd12, 0, 0),
        1'b0, '0);
    add_row(mk_event(4'd1, KIND_RELEASED, -524288, 524287, 9'd200, 1'b1, 32'd5, 0, 0),
        1'b0, '0);
    add_row(mk_event(4'd2, KIND_PRESSED, 100, 100, 9'd256, 1'b1, 32'hFFFF_FFF0, 0, 0),
        1'b0, '0);
    add_row(mk_event(4'd2, KIND_UPDATED, 300, -50, 9'd3, 1'b0, 32'hFFFF_FFF8, 0, 0),
        1'b0, '0);
    add_row(mk_event(4'd2, KIND_STATIONARY, 300, -50, 9'd3, 1'b1, 32'hFFFF_FFFF, 0, 0),
        1'b0, '0);
    add_row(mk_event(4'd2, KIND_UPDATED, 310, -60, 9'd3, 1'b1, 32'hFFFF_FFFF, 0, 0),
        1'b0, '0);
    add_row(mk_event(4'd15, KIND_PRESSED, 7, -7, 9'd257, 1'b1, 32'd1, 32'hFFFF_FFFF,
        32'h8000_0000), 1'b0, '0);
    add_row(mk_event(4'd15, KIND_UPDATED, 9, -9, 9'd1, 1'b1, 32'd2, 32'h7FFF_FFFF,
        32'h0), 1'b0, '0);
    foreach (directed_rows[i]) send_event(directed_rows[i].ev, directed_rows[i].has_exp,
        directed_rows[i].exp_word);
    drain();

    // random phases across gain and device-velocity settings, extremes included
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: write_reg(AddrGain, 32'd0);
        1: write_reg(AddrGain, 32'd256);
        2: write_reg(AddrGain, 32'h1FF);
        3: begin
          write_reg(AddrDevVel, 32'd1);
          write_reg(AddrGain, $urandom_range(0, 511));
        end
        4: begin
          write_reg(AddrDevVel, 32'd0);
          write_reg(AddrGain, 32'hFFFF_FE01);
        end
        default: write_reg(AddrGain, $urandom_range(1, 255));
      endcase
      n = (ph == 5) ? RandItems - 5 * (RandItems / 6) : RandItems / 6;
      for (int i = 0; i < n; i++) begin
        ev = random_event((ph == 1) ? 2 : 15);
        send_event(ev, 1'b0, '0);
      end
      drain();
    end

    $display("run: %0d result words checked, %0d smoothed velocity updates", words_checked,
        vel_updates);
    $display("run: gains 0, 179, 256, above 256 and random; device velocity on and off");
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> touch_point_velocity_tracker_unit.f
hdl/tpvt_pkg.sv
hdl/tpvt_ctrl.sv
hdl/tpvt_datapath.sv
hdl/touch_point_velocity_tracker_unit.sv
tb/sv/tb_touch_point_velocity_tracker_unit.sv
